[hdl/bfsa_pkg.sv]
package bfsa_pkg;

	localparam int SIZE_BITS        = 24;
	localparam int OWNER_BITS       = 16;
	localparam int COUNT_BITS       = 7;
	localparam int MAX_SEGMENTS_DEF = 64;
	localparam logic [SIZE_BITS-1:0] CAPACITY_RESET = '1;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_FREE    = 2'd1,
		MODE_COMPACT = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_HOLE   = 3'd1,
		ST_TOO_SMALL = 3'd2,
		ST_FULL      = 3'd3,
		ST_ABSENT    = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]            mode;
		logic [OWNER_BITS-1:0] owner_id;
		logic [SIZE_BITS-1:0]  request_size;
	} op_t;

	typedef struct packed {
		status_t               status;
		logic [SIZE_BITS-1:0]  free_space;
		logic [COUNT_BITS-1:0] segment_count;
	} res_t;

	typedef struct packed {
		logic [OWNER_BITS-1:0] owner;
		logic [SIZE_BITS-1:0]  len;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CHECK,
		S_ASCAN, S_AEXACT, S_AUP, S_ANEW, S_AREM,
		S_FSCAN, S_FMERGE, S_FDOWN,
		S_CCOUNT, S_CMOVE, S_CTAIL,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		PTR_HOLD, PTR_ZERO, PTR_INC, PTR_DEC, PTR_LAST, PTR_SRC
	} ptr_op_t;

	typedef enum logic [1:0] {
		SCAN_NONE, SCAN_BEST, SCAN_OWNER, SCAN_COUNT
	} scan_t;

	typedef enum logic [3:0] {
		WR_NONE, WR_INIT, WR_UP, WR_DOWN, WR_PACK,
		WR_EXACT, WR_NEW, WR_REM, WR_MERGE, WR_TAIL
	} wr_t;

	typedef enum logic [1:0] {
		N_HOLD, N_INC, N_DIST, N_PACK
	} n_op_t;

	typedef enum logic [1:0] {
		F_HOLD, F_SUB, F_ADD
	} free_op_t;

	typedef struct packed {
		logic     ld_op;
		logic     rd_en;
		ptr_op_t  ptr_op;
		scan_t    scan;
		logic     scan_clr;
		logic     cnt_clr;
		wr_t      wr;
		n_op_t    n_op;
		free_op_t free_op;
		logic     res_ld;
		status_t  res_status;
	} ctl_t;

	typedef struct packed {
		mode_t mode;
		logic  owner_zero;
		logic  size_zero;
		logic  too_small;
		logic  ptr_lt_n;
		logic  ptr_gt_best;
		logic  rv;
		logic  found;
		logic  exact;
		logic  table_full;
		logic  pack_full;
	} sts_t;

endpackage

[hdl/bfsa_datapath.sv]
module bfsa_datapath #(
	parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bfsa_pkg::op_t                  op,
	input  logic                           cfg_wr_en,
	input  logic [bfsa_pkg::SIZE_BITS-1:0] cfg_wr_data,
	input  bfsa_pkg::ctl_t                 ctl,
	output bfsa_pkg::sts_t                 sts,
	output bfsa_pkg::res_t                 res
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int SB = bfsa_pkg::SIZE_BITS;

	bfsa_pkg::entry_t mem [MAX_SEGMENTS];

	bfsa_pkg::op_t      op_q;
	bfsa_pkg::entry_t   rd_q;
	bfsa_pkg::status_t  st_q;
	logic               rv_q;
	logic [IW-1:0]      ra_q;
	logic [CW-1:0]      ptr_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      cnt_q;
	logic [SB-1:0]      free_q;
	logic [SB-1:0]      cap_q;
	logic               found_q;
	logic [1:0]         dist_q;
	logic [IW-1:0]      best_q;
	logic [SB-1:0]      best_len_q;
	logic [bfsa_pkg::OWNER_BITS-1:0] prev_own_q;
	logic [bfsa_pkg::OWNER_BITS-1:0] next_own_q;
	logic [SB-1:0]      prev_len_q;
	logic [SB-1:0]      next_len_q;

	logic               we;
	logic [IW-1:0]      wa;
	bfsa_pkg::entry_t   wd;
	logic               nf;
	logic               pf;
	logic [SB-1:0]      merge_len;
	logic               best_hit;
	logic               own_hit;

	// Neighbors of the released segment that are free and get merged.
	assign nf = ((CW'(best_q) + CW'(1)) < n_q) && (next_own_q == '0);
	assign pf = (best_q != '0) && (prev_own_q == '0);
	assign merge_len = best_len_q + (nf ? next_len_q : '0) + (pf ? prev_len_q : '0);

	assign best_hit = rv_q && (rd_q.owner == '0) && (rd_q.len >= op_q.request_size) &&
		(!found_q || (rd_q.len < best_len_q));
	assign own_hit = rv_q && !found_q && (rd_q.owner == op_q.owner_id);

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = rd_q;
		if (cfg_wr_en) begin
			we = 1'b1;
			wd = '{owner: '0, len: cfg_wr_data};
		end else begin
			unique case (ctl.wr)
				bfsa_pkg::WR_NONE: ;
				bfsa_pkg::WR_INIT: begin
					we = 1'b1;
					wd = '{owner: '0, len: cap_q};
				end
				bfsa_pkg::WR_UP: begin
					we = rv_q;
					wa = ra_q + IW'(1);
				end
				bfsa_pkg::WR_DOWN: begin
					we = rv_q;
					wa = ra_q - IW'(dist_q);
				end
				bfsa_pkg::WR_PACK: begin
					we = rv_q && (rd_q.owner != '0);
					wa = cnt_q[IW-1:0];
				end
				bfsa_pkg::WR_EXACT, bfsa_pkg::WR_NEW: begin
					we = 1'b1;
					wa = best_q;
					wd = '{owner: op_q.owner_id, len: op_q.request_size};
				end
				bfsa_pkg::WR_REM: begin
					we = 1'b1;
					wa = best_q + IW'(1);
					wd = '{owner: '0, len: best_len_q - op_q.request_size};
				end
				bfsa_pkg::WR_MERGE: begin
					we = 1'b1;
					wa = pf ? (best_q - IW'(1)) : best_q;
					wd = '{owner: '0, len: merge_len};
				end
				bfsa_pkg::WR_TAIL: begin
					we = 1'b1;
					wa = cnt_q[IW-1:0];
					wd = '{owner: '0, len: free_q};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[ptr_q[IW-1:0]];
			ra_q <= ptr_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_op) begin
			op_q <= op;
		end
		if ((ctl.scan == bfsa_pkg::SCAN_BEST && best_hit) ||
				(ctl.scan == bfsa_pkg::SCAN_OWNER && own_hit)) begin
			best_q     <= ra_q;
			best_len_q <= rd_q.len;
		end
		if (ctl.scan == bfsa_pkg::SCAN_OWNER && rv_q) begin
			if (!found_q && !own_hit) begin
				prev_own_q <= rd_q.owner;
				prev_len_q <= rd_q.len;
			end else if (found_q) begin
				next_own_q <= rd_q.owner;
				next_len_q <= rd_q.len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q    <= 1'b0;
			ptr_q   <= '0;
			n_q     <= CW'(1);
			cnt_q   <= '0;
			free_q  <= bfsa_pkg::CAPACITY_RESET;
			cap_q   <= bfsa_pkg::CAPACITY_RESET;
			found_q <= 1'b0;
			dist_q  <= '0;
			st_q    <= bfsa_pkg::ST_OK;
		end else begin
			rv_q <= ctl.rd_en;
			unique case (ctl.ptr_op)
				bfsa_pkg::PTR_HOLD: ;
				bfsa_pkg::PTR_ZERO: ptr_q <= '0;
				bfsa_pkg::PTR_INC:  ptr_q <= ptr_q + CW'(1);
				bfsa_pkg::PTR_DEC:  ptr_q <= ptr_q - CW'(1);
				bfsa_pkg::PTR_LAST: ptr_q <= n_q - CW'(1);
				bfsa_pkg::PTR_SRC:  ptr_q <= CW'(best_q) + CW'(1) + CW'(nf);
				default: ;
			endcase
			if (ctl.scan_clr) begin
				found_q <= 1'b0;
			end else if ((ctl.scan == bfsa_pkg::SCAN_BEST && best_hit) ||
					(ctl.scan == bfsa_pkg::SCAN_OWNER && own_hit)) begin
				found_q <= 1'b1;
			end
			if (ctl.cnt_clr) begin
				cnt_q <= '0;
			end else if (ctl.scan == bfsa_pkg::SCAN_COUNT && rv_q && rd_q.owner != '0) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (ctl.wr == bfsa_pkg::WR_MERGE) begin
				dist_q <= 2'(nf) + 2'(pf);
			end
			if (ctl.res_ld) begin
				st_q <= ctl.res_status;
			end
			if (cfg_wr_en) begin
				cap_q  <= cfg_wr_data;
				free_q <= cfg_wr_data;
				n_q    <= CW'(1);
			end else begin
				unique case (ctl.n_op)
					bfsa_pkg::N_HOLD: ;
					bfsa_pkg::N_INC:  n_q <= n_q + CW'(1);
					bfsa_pkg::N_DIST: n_q <= n_q - CW'(dist_q);
					bfsa_pkg::N_PACK: n_q <= cnt_q + CW'(1);
					default: ;
				endcase
				unique case (ctl.free_op)
					bfsa_pkg::F_HOLD: ;
					bfsa_pkg::F_SUB:  free_q <= free_q - op_q.request_size;
					bfsa_pkg::F_ADD:  free_q <= free_q + best_len_q;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		sts.mode        = bfsa_pkg::mode_t'(op_q.mode);
		sts.owner_zero  = (op_q.owner_id == '0);
		sts.size_zero   = (op_q.request_size == '0);
		sts.too_small   = (free_q < op_q.request_size);
		sts.ptr_lt_n    = (ptr_q < n_q);
		sts.ptr_gt_best = (ptr_q > CW'(best_q));
		sts.rv          = rv_q;
		sts.found       = found_q;
		sts.exact       = (best_len_q == op_q.request_size);
		sts.table_full  = (n_q >= CW'(MAX_SEGMENTS));
		sts.pack_full   = (cnt_q >= CW'(MAX_SEGMENTS));
	end

	assign res.status        = st_q;
	assign res.free_space    = free_q;
	assign res.segment_count = bfsa_pkg::COUNT_BITS'(n_q);

endmodule

[hdl/bfsa_ctrl.sv]
module bfsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bfsa_pkg::sts_t sts,
	output bfsa_pkg::ctl_t ctl,
	output logic           busy,
	output logic           result_valid
);

	bfsa_pkg::state_t state_q;
	bfsa_pkg::state_t state_d;
	logic             pass_done;

	// A pass is over once no read is issued and none is in flight.
	assign pass_done = !ctl.rd_en && !sts.rv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfsa_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfsa_pkg::S_INIT: state_d = bfsa_pkg::S_IDLE;
			bfsa_pkg::S_IDLE: begin
				if (start) begin
					state_d = bfsa_pkg::S_CHECK;
				end
			end
			bfsa_pkg::S_CHECK: begin
				unique case (sts.mode)
					bfsa_pkg::MODE_ALLOC: begin
						if (sts.owner_zero || sts.size_zero || sts.too_small) begin
							state_d = bfsa_pkg::S_DONE;
						end else begin
							state_d = bfsa_pkg::S_ASCAN;
						end
					end
					bfsa_pkg::MODE_FREE: begin
						state_d = sts.owner_zero ? bfsa_pkg::S_DONE : bfsa_pkg::S_FSCAN;
					end
					bfsa_pkg::MODE_COMPACT: state_d = bfsa_pkg::S_CCOUNT;
					bfsa_pkg::MODE_NONE: state_d = bfsa_pkg::S_DONE;
					default: state_d = bfsa_pkg::S_DONE;
				endcase
			end
			bfsa_pkg::S_ASCAN: begin
				if (pass_done) begin
					priority if (!sts.found) state_d = bfsa_pkg::S_DONE;
					else if (sts.exact) state_d = bfsa_pkg::S_AEXACT;
					else if (sts.table_full) state_d = bfsa_pkg::S_DONE;
					else state_d = bfsa_pkg::S_AUP;
				end
			end
			bfsa_pkg::S_AEXACT: state_d = bfsa_pkg::S_DONE;
			bfsa_pkg::S_AUP: begin
				if (pass_done) begin
					state_d = bfsa_pkg::S_ANEW;
				end
			end
			bfsa_pkg::S_ANEW: state_d = bfsa_pkg::S_AREM;
			bfsa_pkg::S_AREM: state_d = bfsa_pkg::S_DONE;
			bfsa_pkg::S_FSCAN: begin
				if (pass_done) begin
					state_d = sts.found ? bfsa_pkg::S_FMERGE : bfsa_pkg::S_DONE;
				end
			end
			bfsa_pkg::S_FMERGE: state_d = bfsa_pkg::S_FDOWN;
			bfsa_pkg::S_FDOWN: begin
				if (pass_done) begin
					state_d = bfsa_pkg::S_DONE;
				end
			end
			bfsa_pkg::S_CCOUNT: begin
				if (pass_done) begin
					state_d = sts.pack_full ? bfsa_pkg::S_DONE : bfsa_pkg::S_CMOVE;
				end
			end
			bfsa_pkg::S_CMOVE: begin
				if (pass_done) begin
					state_d = bfsa_pkg::S_CTAIL;
				end
			end
			bfsa_pkg::S_CTAIL: state_d = bfsa_pkg::S_DONE;
			bfsa_pkg::S_DONE: state_d = bfsa_pkg::S_IDLE;
			default: state_d = bfsa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl.ld_op      = 1'b0;
		ctl.rd_en      = 1'b0;
		ctl.ptr_op     = bfsa_pkg::PTR_HOLD;
		ctl.scan       = bfsa_pkg::SCAN_NONE;
		ctl.scan_clr   = 1'b0;
		ctl.cnt_clr    = 1'b0;
		ctl.wr         = bfsa_pkg::WR_NONE;
		ctl.n_op       = bfsa_pkg::N_HOLD;
		ctl.free_op    = bfsa_pkg::F_HOLD;
		ctl.res_ld     = 1'b0;
		ctl.res_status = bfsa_pkg::ST_OK;
		busy           = 1'b1;
		result_valid   = 1'b0;
		unique case (state_q)
			bfsa_pkg::S_INIT: ctl.wr = bfsa_pkg::WR_INIT;
			bfsa_pkg::S_IDLE: begin
				busy      = 1'b0;
				ctl.ld_op = start;
			end
			bfsa_pkg::S_CHECK: begin
				ctl.ptr_op   = bfsa_pkg::PTR_ZERO;
				ctl.scan_clr = 1'b1;
				ctl.cnt_clr  = 1'b1;
				ctl.res_ld   = 1'b1;
				unique case (sts.mode)
					bfsa_pkg::MODE_ALLOC: begin
						priority if (sts.owner_zero) ctl.res_status = bfsa_pkg::ST_ABSENT;
						else if (sts.size_zero) ctl.res_status = bfsa_pkg::ST_OK;
						else if (sts.too_small) ctl.res_status = bfsa_pkg::ST_TOO_SMALL;
						else ctl.res_status = bfsa_pkg::ST_OK;
					end
					bfsa_pkg::MODE_FREE: begin
						ctl.res_status = sts.owner_zero ? bfsa_pkg::ST_ABSENT : bfsa_pkg::ST_OK;
					end
					bfsa_pkg::MODE_COMPACT, bfsa_pkg::MODE_NONE: ctl.res_status = bfsa_pkg::ST_OK;
					default: ctl.res_status = bfsa_pkg::ST_OK;
				endcase
			end
			bfsa_pkg::S_ASCAN: begin
				ctl.rd_en  = sts.ptr_lt_n;
				ctl.ptr_op = sts.ptr_lt_n ? bfsa_pkg::PTR_INC : bfsa_pkg::PTR_HOLD;
				ctl.scan   = bfsa_pkg::SCAN_BEST;
				if (!sts.ptr_lt_n && !sts.rv) begin
					ctl.ptr_op = bfsa_pkg::PTR_LAST;
					if (!sts.found) begin
						ctl.res_ld     = 1'b1;
						ctl.res_status = bfsa_pkg::ST_NO_HOLE;
					end else if (!sts.exact && sts.table_full) begin
						ctl.res_ld     = 1'b1;
						ctl.res_status = bfsa_pkg::ST_FULL;
					end
				end
			end
			bfsa_pkg::S_AEXACT: begin
				ctl.wr      = bfsa_pkg::WR_EXACT;
				ctl.free_op = bfsa_pkg::F_SUB;
			end
			bfsa_pkg::S_AUP: begin
				ctl.rd_en  = sts.ptr_gt_best;
				ctl.ptr_op = sts.ptr_gt_best ? bfsa_pkg::PTR_DEC : bfsa_pkg::PTR_HOLD;
				ctl.wr     = bfsa_pkg::WR_UP;
			end
			bfsa_pkg::S_ANEW: ctl.wr = bfsa_pkg::WR_NEW;
			bfsa_pkg::S_AREM: begin
				ctl.wr      = bfsa_pkg::WR_REM;
				ctl.n_op    = bfsa_pkg::N_INC;
				ctl.free_op = bfsa_pkg::F_SUB;
			end
			bfsa_pkg::S_FSCAN: begin
				ctl.rd_en  = sts.ptr_lt_n && !sts.found;
				ctl.ptr_op = ctl.rd_en ? bfsa_pkg::PTR_INC : bfsa_pkg::PTR_HOLD;
				ctl.scan   = bfsa_pkg::SCAN_OWNER;
				if (!ctl.rd_en && !sts.rv && !sts.found) begin
					ctl.res_ld     = 1'b1;
					ctl.res_status = bfsa_pkg::ST_ABSENT;
				end
			end
			bfsa_pkg::S_FMERGE: begin
				ctl.wr      = bfsa_pkg::WR_MERGE;
				ctl.free_op = bfsa_pkg::F_ADD;
				ctl.ptr_op  = bfsa_pkg::PTR_SRC;
			end
			bfsa_pkg::S_FDOWN: begin
				ctl.rd_en  = sts.ptr_lt_n;
				ctl.ptr_op = sts.ptr_lt_n ? bfsa_pkg::PTR_INC : bfsa_pkg::PTR_HOLD;
				ctl.wr     = bfsa_pkg::WR_DOWN;
				if (!sts.ptr_lt_n && !sts.rv) begin
					ctl.n_op = bfsa_pkg::N_DIST;
				end
			end
			bfsa_pkg::S_CCOUNT: begin
				ctl.rd_en  = sts.ptr_lt_n;
				ctl.ptr_op = sts.ptr_lt_n ? bfsa_pkg::PTR_INC : bfsa_pkg::PTR_HOLD;
				ctl.scan   = bfsa_pkg::SCAN_COUNT;
				if (!sts.ptr_lt_n && !sts.rv) begin
					ctl.ptr_op  = bfsa_pkg::PTR_ZERO;
					ctl.cnt_clr = 1'b1;
					if (sts.pack_full) begin
						ctl.res_ld     = 1'b1;
						ctl.res_status = bfsa_pkg::ST_FULL;
					end
				end
			end
			bfsa_pkg::S_CMOVE: begin
				ctl.rd_en  = sts.ptr_lt_n;
				ctl.ptr_op = sts.ptr_lt_n ? bfsa_pkg::PTR_INC : bfsa_pkg::PTR_HOLD;
				ctl.scan   = bfsa_pkg::SCAN_COUNT;
				ctl.wr     = bfsa_pkg::WR_PACK;
			end
			bfsa_pkg::S_CTAIL: begin
				ctl.wr   = bfsa_pkg::WR_TAIL;
				ctl.n_op = bfsa_pkg::N_PACK;
			end
			bfsa_pkg::S_DONE: result_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

[hdl/best_fit_segment_allocator.sv]
// A beat rejected or settled at the check goes straight to the result strobe; an
// allocate, free or compact first runs its passes over the segment table, so its
// time grows with the segment count. Each pass reads one entry a cycle; the segment
// memory has a separate read port and write port.
// Throughput: one beat at a time; busy stays high through the result strobe cycle and
// drops in the idle state that follows, where the next beat can be accepted.
// Reset (arst_n, asynchronous, active low) sets the capacity to its maximum and writes
// the single free segment in the init state; the result side cannot stall.
module best_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  bfsa_pkg::op_t                  op,
	output logic                           busy,
	output logic                           result_valid,
	output bfsa_pkg::res_t                 result,
	input  logic                           cfg_wr_en,
	input  logic [bfsa_pkg::SIZE_BITS-1:0] cfg_wr_data
);

	// The controller sequences the scan, shift and compaction passes; the datapath
	// owns the segment table memory, the pass pointer and the running totals.
	bfsa_pkg::ctl_t ctl;
	bfsa_pkg::sts_t sts;

	bfsa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.sts          (sts),
		.ctl          (ctl),
		.busy         (busy),
		.result_valid (result_valid)
	);

	// A capacity write reloads the table to one free segment in the same cycle.
	bfsa_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ctl         (ctl),
		.sts         (sts),
		.res         (result)
	);

endmodule

[hdl/bfsa_checker.sv]
module bfsa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           result_valid,
	input bfsa_pkg::res_t result
);

	// Each result beat lasts exactly one cycle.
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held longer than one cycle");

	// An accepted beat makes the block busy.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// A result only appears while a beat is in flight.
	a_result_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while idle");

	// The table holds at least one segment whenever a result is shown.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.segment_count != '0))
		else $error("segment count reported as zero");

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

[tb/tb_best_fit_segment_allocator.sv]
module tb_best_fit_segment_allocator;

	localparam int NSEG = bfsa_pkg::MAX_SEGMENTS_DEF;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic start;
	bfsa_pkg::op_t op;
	logic busy;
	logic result_valid;
	bfsa_pkg::res_t result;
	logic cfg_wr_en;
	logic [bfsa_pkg::SIZE_BITS-1:0] cfg_wr_data;

	best_fit_segment_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.op(op),
		.busy(busy),
		.result_valid(result_valid),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Shadow copy of the segment table. Each accepted beat is run through the
	// allocator model below and the answer is queued until the strobe shows up.
	logic [bfsa_pkg::OWNER_BITS-1:0] shadow_owner [NSEG];
	logic [bfsa_pkg::SIZE_BITS-1:0] shadow_len [NSEG];
	int shadow_count;
	logic [bfsa_pkg::SIZE_BITS-1:0] shadow_free;
	bfsa_pkg::res_t pending_results[$];
	int errors;
	int cycle_count;
	int idle_pct;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	function automatic void shadow_init(input logic [bfsa_pkg::SIZE_BITS-1:0] cap);
		shadow_owner[0] = '0;
		shadow_len[0] = cap;
		shadow_count = 1;
		shadow_free = cap;
	endfunction

	function automatic void shadow_remove(input int pos);
		for (int k = pos; k + 1 < shadow_count; k++) begin
			shadow_owner[k] = shadow_owner[k+1];
			shadow_len[k] = shadow_len[k+1];
		end
		shadow_count--;
	endfunction

	function automatic bfsa_pkg::status_t alloc_segment(
			input logic [bfsa_pkg::OWNER_BITS-1:0] who,
			input logic [bfsa_pkg::SIZE_BITS-1:0] sz);
		int best;
		best = -1;
		if (who == 0) return bfsa_pkg::ST_ABSENT;
		if (sz == 0) return bfsa_pkg::ST_OK;
		if (shadow_free < sz) return bfsa_pkg::ST_TOO_SMALL;
		for (int k = 0; k < shadow_count; k++)
			if (shadow_owner[k] == 0 && shadow_len[k] >= sz)
				if (best < 0 || shadow_len[k] < shadow_len[best]) best = k;
		if (best < 0) return bfsa_pkg::ST_NO_HOLE;
		if (shadow_len[best] == sz) begin
			shadow_owner[best] = who;
		end else begin
			if (shadow_count >= NSEG) return bfsa_pkg::ST_FULL;
			for (int k = shadow_count; k > best; k--) begin
				shadow_owner[k] = shadow_owner[k-1];
				shadow_len[k] = shadow_len[k-1];
			end
			shadow_count++;
			shadow_owner[best] = who;
			shadow_len[best] = sz;
			shadow_len[best+1] = shadow_len[best+1] - sz;
		end
		shadow_free = shadow_free - sz;
		return bfsa_pkg::ST_OK;
	endfunction

	function automatic bfsa_pkg::status_t release_owner(
			input logic [bfsa_pkg::OWNER_BITS-1:0] who);
		int k;
		k = 0;
		if (who == 0) return bfsa_pkg::ST_ABSENT;
		while (k < shadow_count && shadow_owner[k] != who) k++;
		if (k >= shadow_count) return bfsa_pkg::ST_ABSENT;
		shadow_owner[k] = '0;
		shadow_free = shadow_free + shadow_len[k];
		if (k + 1 < shadow_count && shadow_owner[k+1] == 0) begin
			shadow_len[k] = shadow_len[k] + shadow_len[k+1];
			shadow_remove(k + 1);
		end
		if (k > 0 && shadow_owner[k-1] == 0) begin
			shadow_len[k-1] = shadow_len[k-1] + shadow_len[k];
			shadow_remove(k);
		end
		return bfsa_pkg::ST_OK;
	endfunction

	function automatic bfsa_pkg::status_t compact_table();
		int w;
		w = 0;
		for (int k = 0; k < shadow_count; k++)
			if (shadow_owner[k] != 0) w++;
		if (w >= NSEG) return bfsa_pkg::ST_FULL;
		w = 0;
		for (int k = 0; k < shadow_count; k++)
			if (shadow_owner[k] != 0) begin
				shadow_owner[w] = shadow_owner[k];
				shadow_len[w] = shadow_len[k];
				w++;
			end
		shadow_owner[w] = '0;
		shadow_len[w] = shadow_free;
		shadow_count = w + 1;
		return bfsa_pkg::ST_OK;
	endfunction

	function automatic bfsa_pkg::res_t predict_result(input bfsa_pkg::op_t o);
		bfsa_pkg::res_t r;
		r.status = bfsa_pkg::ST_OK;
		case (bfsa_pkg::mode_t'(o.mode))
			bfsa_pkg::MODE_ALLOC: r.status = alloc_segment(o.owner_id, o.request_size);
			bfsa_pkg::MODE_FREE: r.status = release_owner(o.owner_id);
			bfsa_pkg::MODE_COMPACT: r.status = compact_table();
			default: r.status = bfsa_pkg::ST_OK;
		endcase
		r.free_space = shadow_free;
		r.segment_count = bfsa_pkg::COUNT_BITS'(shadow_count);
		return r;
	endfunction

	// Result side: every strobe is compared with the oldest queued answer.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				report_mismatch("queued answers at result beat", 0, 1);
			end else begin
				bfsa_pkg::res_t want;
				want = pending_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
				if (result.free_space !== want.free_space)
					report_mismatch("free_space", result.free_space, want.free_space);
				if (result.segment_count !== want.segment_count)
					report_mismatch("segment_count", result.segment_count,
						want.segment_count);
			end
		end
	end

	// Watchdog: ends the run with an error once the total cycle count passes CYCLE_LIMIT.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[best_fit_segment_allocator] ERROR");
			$finish;
		end
	end

	// Send one beat: optional random idle gap, then hold start until it is taken.
	// Start stays high on return; the next call or a drain decides its next value.
	task automatic send_beat(input bfsa_pkg::op_t o);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predict_result(o));
	endtask

	// Wait until the queue drains, plus slack for a beat that might still be running.
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Capacity writes happen only when the block is quiet.
	task automatic write_capacity(input logic [bfsa_pkg::SIZE_BITS-1:0] cap);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_init(cap);
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic bfsa_pkg::op_t make_op(input bfsa_pkg::mode_t m, input int who,
			input int sz);
		bfsa_pkg::op_t o;
		o.mode = m;
		o.owner_id = bfsa_pkg::OWNER_BITS'(who);
		o.request_size = bfsa_pkg::SIZE_BITS'(sz);
		return o;
	endfunction

	// Directed table. A typed expectation is checked on top of the predictor;
	// rows with has_want clear rely on the predictor alone.
	typedef struct {
		bfsa_pkg::op_t o;
		logic has_want;
		bfsa_pkg::res_t want;
	} dir_row_t;

	function automatic dir_row_t row(input bfsa_pkg::mode_t m, input int who, input int sz,
			input logic hw, input bfsa_pkg::status_t st, input int fs, input int sc);
		dir_row_t d;
		d.o = make_op(m, who, sz);
		d.has_want = hw;
		d.want.status = st;
		d.want.free_space = bfsa_pkg::SIZE_BITS'(fs);
		d.want.segment_count = bfsa_pkg::COUNT_BITS'(sc);
		return d;
	endfunction

	// Random beat with small sizes so that holes are reused and the table fills.
	function automatic bfsa_pkg::op_t random_op(input int cap_hint, input int owners);
		bfsa_pkg::op_t o;
		int pick;
		pick = $urandom_range(99, 0);
		o.owner_id = bfsa_pkg::OWNER_BITS'($urandom_range(owners, 1));
		o.request_size = bfsa_pkg::SIZE_BITS'($urandom_range(cap_hint / 8 + 1, 1));
		if (pick < 50) o.mode = bfsa_pkg::MODE_ALLOC;
		else if (pick < 85) o.mode = bfsa_pkg::MODE_FREE;
		else if (pick < 93) o.mode = bfsa_pkg::MODE_COMPACT;
		else begin
			// Noise: wild fields, owner zero, zero size and the unused mode.
			o = bfsa_pkg::op_t'(($bits(bfsa_pkg::op_t))'({$urandom, $urandom}));
		end
		return o;
	endfunction

	initial begin
		dir_row_t dir_rows[$];
		bfsa_pkg::res_t exp_r;
		int caps[6];

		errors = 0;
		cycle_count = 0;
		idle_pct = 0;
		start = 1'b0;
		op = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		shadow_init(bfsa_pkg::CAPACITY_RESET);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// Directed part, first from the reset table (full capacity, one hole).
		dir_rows.push_back(row(bfsa_pkg::MODE_COMPACT, 0, 0, 1'b1, bfsa_pkg::ST_OK,
			24'hFFFFFF, 1));
		dir_rows.push_back(row(bfsa_pkg::MODE_ALLOC, 0, 5, 1'b1, bfsa_pkg::ST_ABSENT,
			24'hFFFFFF, 1));
		dir_rows.push_back(row(bfsa_pkg::MODE_ALLOC, 7, 0, 1'b1, bfsa_pkg::ST_OK,
			24'hFFFFFF, 1));
		dir_rows.push_back(row(bfsa_pkg::MODE_FREE, 0, 0, 1'b1, bfsa_pkg::ST_ABSENT,
			24'hFFFFFF, 1));
		dir_rows.push_back(row(bfsa_pkg::MODE_FREE, 9, 0, 1'b1, bfsa_pkg::ST_ABSENT,
			24'hFFFFFF, 1));
		dir_rows.push_back(row(bfsa_pkg::MODE_NONE, 16'hFFFF, 24'hFFFFFF, 1'b1,
			bfsa_pkg::ST_OK, 24'hFFFFFF, 1));
		dir_rows.push_back(row(bfsa_pkg::MODE_ALLOC, 16'hFFFF, 1, 1'b1, bfsa_pkg::ST_OK,
			24'hFFFFFE, 2));
		dir_rows.push_back(row(bfsa_pkg::MODE_ALLOC, 2, 24'hFFFFFF, 1'b1,
			bfsa_pkg::ST_TOO_SMALL, 24'hFFFFFE, 2));
		dir_rows.push_back(row(bfsa_pkg::MODE_ALLOC, 3, 100, 1'b0, bfsa_pkg::ST_OK, 0, 0));
		dir_rows.push_back(row(bfsa_pkg::MODE_ALLOC, 4, 50, 1'b0, bfsa_pkg::ST_OK, 0, 0));
		dir_rows.push_back(row(bfsa_pkg::MODE_FREE, 3, 0, 1'b0, bfsa_pkg::ST_OK, 0, 0));
		dir_rows.push_back(row(bfsa_pkg::MODE_ALLOC, 5, 40, 1'b0, bfsa_pkg::ST_OK, 0, 0));
		dir_rows.push_back(row(bfsa_pkg::MODE_ALLOC, 5, 60, 1'b0, bfsa_pkg::ST_OK, 0, 0));
		dir_rows.push_back(row(bfsa_pkg::MODE_FREE, 5, 0, 1'b0, bfsa_pkg::ST_OK, 0, 0));
		dir_rows.push_back(row(bfsa_pkg::MODE_COMPACT, 0, 0, 1'b0, bfsa_pkg::ST_OK, 0, 0));
		dir_rows.push_back(row(bfsa_pkg::MODE_ALLOC, 6, 24'hFFFF00, 1'b0, bfsa_pkg::ST_OK,
			0, 0));
		dir_rows.push_back(row(bfsa_pkg::MODE_ALLOC, 8, 24'hFFFF, 1'b0, bfsa_pkg::ST_OK,
			0, 0));
		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].o);
			exp_r = pending_results[$];
			if (dir_rows[i].has_want) begin
				if (exp_r.status !== dir_rows[i].want.status)
					report_mismatch("directed status", exp_r.status,
						dir_rows[i].want.status);
				if (exp_r.free_space !== dir_rows[i].want.free_space)
					report_mismatch("directed free_space", exp_r.free_space,
						dir_rows[i].want.free_space);
				if (exp_r.segment_count !== dir_rows[i].want.segment_count)
					report_mismatch("directed segment_count", exp_r.segment_count,
						dir_rows[i].want.segment_count);
			end
		end

		// A tiny capacity: exact fits, no fitting hole, zero-length tail.
		write_capacity(bfsa_pkg::SIZE_BITS'(10));
		send_beat(make_op(bfsa_pkg::MODE_ALLOC, 1, 4));
		send_beat(make_op(bfsa_pkg::MODE_ALLOC, 2, 2));
		send_beat(make_op(bfsa_pkg::MODE_ALLOC, 3, 4));
		send_beat(make_op(bfsa_pkg::MODE_FREE, 1, 0));
		send_beat(make_op(bfsa_pkg::MODE_FREE, 3, 0));
		send_beat(make_op(bfsa_pkg::MODE_ALLOC, 4, 5));
		send_beat(make_op(bfsa_pkg::MODE_COMPACT, 0, 0));
		write_capacity('0);
		send_beat(make_op(bfsa_pkg::MODE_ALLOC, 1, 1));
		send_beat(make_op(bfsa_pkg::MODE_COMPACT, 0, 0));

		// Table full: unit-sized beats fill all entries, then split and compact fail.
		write_capacity(bfsa_pkg::SIZE_BITS'(NSEG));
		for (int k = 1; k <= NSEG; k++) send_beat(make_op(bfsa_pkg::MODE_ALLOC, k, 1));
		send_beat(make_op(bfsa_pkg::MODE_COMPACT, 0, 0));
		send_beat(make_op(bfsa_pkg::MODE_FREE, 2, 0));
		write_capacity(bfsa_pkg::SIZE_BITS'(NSEG + 10));
		for (int k = 1; k < NSEG; k++) send_beat(make_op(bfsa_pkg::MODE_ALLOC, k, 1));
		send_beat(make_op(bfsa_pkg::MODE_ALLOC, 99, 2));
		send_beat(make_op(bfsa_pkg::MODE_ALLOC, 99, 11));
		send_beat(make_op(bfsa_pkg::MODE_ALLOC, 99, 10));

		// Random part in phases of idle pressure and capacity; owners stay few
		// so that frees mostly hit and the table churns near full.
		caps[0] = 1;
		caps[1] = 24'hFFFFFF;
		caps[2] = 300;
		caps[3] = 5000;
		caps[4] = 64;
		caps[5] = 24'h800000;
		for (int ph = 0; ph < 6; ph++) begin
			int cap;
			cap = caps[ph];
			write_capacity(bfsa_pkg::SIZE_BITS'(cap));
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 82;
				2: idle_pct = 16;
				default: idle_pct = 50;
			endcase
			for (int n = 0; n < 300; n++) begin
				send_beat(random_op(cap > 4000 ? 4000 : cap, 40));
				if (n == 150) wait_drained();
			end
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[best_fit_segment_allocator] OK");
		end else begin
			$display("[best_fit_segment_allocator] ERROR");
		end
		$finish;
	end

endmodule

[files.f]
hdl/bfsa_pkg.sv
hdl/bfsa_datapath.sv
hdl/bfsa_ctrl.sv
hdl/best_fit_segment_allocator.sv
hdl/bfsa_checker.sv
tb/tb_best_fit_segment_allocator.sv
